// ===== rtl/gls_pkg.sv =====
`default_nettype none
package gls_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int PASS_W     = 8;
  localparam int MODE_W     = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PASSES  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd3;

  // boundary modes
  localparam logic [MODE_W-1:0] MODE_SEAM = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRAP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ZERO = 2'd2;

  localparam logic [0:0] ACT_LOAD = 1'b0;

  typedef struct packed {
    logic              start;
    logic [MODE_W-1:0] mode;
    logic [PASS_W-1:0] passes;
  } job_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic buf_sel;
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/gls_frame_mem.sv =====
`default_nettype none
module gls_frame_mem #(
  parameter int AW = 17,
  parameter int DW = 16
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  localparam int DEPTH = 1 << AW;

  logic [DW-1:0] mem_q [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_q[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/gls_pass_seq.sv =====
`default_nettype none
module gls_pass_seq #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS = 256,
  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS,
  localparam int AW = $clog2(DEPTH),
  localparam int PW = $clog2(DEPTH + 1),
  localparam int CW = $clog2(((MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS) + 1),
  localparam int SW = gls_pkg::SAMPLE_W
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire gls_pkg::job_t job_i,
  input  wire logic [CW-1:0] cols_i,
  input  wire logic [CW-1:0] rows_i,
  input  wire logic [PW-1:0] total_i,
  input  wire logic          src_buf_i,
  output gls_pkg::stat_t     stat_o,
  output logic               rd_en_o,
  output logic [AW:0]        rd_addr_o,
  input  wire logic [SW-1:0] rd_data_i,
  output logic               wr_en_o,
  output logic [AW:0]        wr_addr_o,
  output logic [SW-1:0]      wr_data_o
);
  import gls_pkg::*;

  localparam int XW = $clog2(MAX_COLUMNS);
  localparam int YW = $clog2(MAX_ROWS);
  localparam int ACC_W = SW + 3;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CELL = 2'd1;
  localparam logic [1:0] S_CPRD = 2'd2;
  localparam logic [1:0] S_CPWR = 2'd3;

  logic [1:0]        st_r, st_nxt;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [CW-1:0]     cols_r, cols_nxt, rows_r, rows_nxt;
  logic [AW-1:0]     lastb_r, lastb_nxt;
  logic [PASS_W-1:0] left_r, left_nxt;
  logic              buf_r, buf_nxt;
  logic              done_r, done_nxt;
  logic [XW-1:0]     i_r, i_nxt;
  logic [YW-1:0]     j_r, j_nxt;
  logic [AW-1:0]     base_r, base_nxt;
  logic [2:0]        k_r, k_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic              zero_r, zero_nxt;

  logic              last_col, first_col, last_row, seam_row, first_row, row_end;
  logic [AW-1:0]     cols_a, rowb, addr;
  logic [XW-1:0]     col;
  logic              nb_zero;
  logic [ACC_W-1:0]  addend, sum;
  logic              pass_end;

  assign cols_a    = AW'(cols_r);
  assign last_col  = (CW'(i_r) == cols_r - CW'(1));
  assign first_col = (i_r == '0);
  assign last_row  = (CW'(j_r) == rows_r - CW'(1));
  assign seam_row  = (CW'(j_r) >= rows_r - CW'(2));
  assign first_row = (j_r == '0);
  assign row_end   = (mode_r == MODE_SEAM) ? seam_row : last_row;

  // neighbor address for the current step: center, right, left, down, up
  always_comb begin
    rowb    = base_r;
    col     = i_r;
    nb_zero = 1'b0;
    case (k_r)
      3'd1: begin
        if (last_col) begin
          if (mode_r == MODE_WRAP) col = '0;
          else if (mode_r != MODE_SEAM) nb_zero = 1'b1;
        end else begin
          col = i_r + XW'(1);
        end
      end
      3'd2: begin
        if (first_col) begin
          if (mode_r == MODE_WRAP) col = XW'(cols_r - CW'(1));
          else if (mode_r != MODE_SEAM) nb_zero = 1'b1;
        end else begin
          col = i_r - XW'(1);
        end
      end
      3'd3: begin
        rowb = base_r + cols_a;
        if (mode_r == MODE_SEAM) begin
          if (seam_row) rowb = '0;
        end else if (mode_r == MODE_WRAP) begin
          if (last_row) rowb = base_r;
        end else if (last_row) begin
          nb_zero = 1'b1;
        end
      end
      3'd4: begin
        rowb = base_r - cols_a;
        if (first_row) begin
          if (mode_r == MODE_SEAM) rowb = lastb_r - cols_a;
          else if (mode_r == MODE_WRAP) rowb = base_r;
          else nb_zero = 1'b1;
        end
      end
      default: begin
        rowb = base_r;
      end
    endcase
  end

  assign addr   = rowb + AW'(col);
  assign addend = zero_r ? '0 :
                  (k_r == 3'd1) ? {1'b0, rd_data_i, 2'b00} : ACC_W'(rd_data_i);
  assign sum    = acc_r + addend;

  always_comb begin
    rd_en_o   = 1'b0;
    rd_addr_o = {buf_r, addr};
    wr_en_o   = 1'b0;
    wr_addr_o = {~buf_r, base_r + AW'(i_r)};
    wr_data_o = sum[ACC_W-1:3];
    case (st_r)
      S_CELL: begin
        rd_en_o = (k_r <= 3'd4);
        wr_en_o = (k_r == 3'd5);
      end
      S_CPRD: begin
        rd_en_o   = 1'b1;
        rd_addr_o = {~buf_r, AW'(i_r)};
      end
      S_CPWR: begin
        wr_en_o   = 1'b1;
        wr_addr_o = {~buf_r, lastb_r + AW'(i_r)};
        wr_data_o = rd_data_i;
      end
      default: begin
        rd_en_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    st_nxt    = st_r;
    mode_nxt  = mode_r;
    cols_nxt  = cols_r;
    rows_nxt  = rows_r;
    lastb_nxt = lastb_r;
    left_nxt  = left_r;
    buf_nxt   = buf_r;
    done_nxt  = 1'b0;
    i_nxt     = i_r;
    j_nxt     = j_r;
    base_nxt  = base_r;
    k_nxt     = k_r;
    acc_nxt   = acc_r;
    zero_nxt  = nb_zero;
    pass_end  = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (job_i.start) begin
          st_nxt    = S_CELL;
          mode_nxt  = (job_i.mode == MODE_SEAM || job_i.mode == MODE_WRAP) ?
                      job_i.mode : MODE_ZERO;
          cols_nxt  = cols_i;
          rows_nxt  = rows_i;
          lastb_nxt = AW'(total_i - PW'(cols_i));
          left_nxt  = job_i.passes;
          buf_nxt   = src_buf_i;
          i_nxt     = '0;
          j_nxt     = '0;
          base_nxt  = '0;
          k_nxt     = '0;
        end
      end
      S_CELL: begin
        acc_nxt = (k_r == 3'd0) ? ACC_W'(4) : sum;
        k_nxt   = k_r + 3'd1;
        if (k_r == 3'd5) begin
          k_nxt = '0;
          if (last_col) begin
            i_nxt = '0;
            if (row_end) begin
              if (mode_r == MODE_SEAM) st_nxt = S_CPRD;
              else pass_end = 1'b1;
            end else begin
              j_nxt    = j_r + YW'(1);
              base_nxt = base_r + cols_a;
            end
          end else begin
            i_nxt = i_r + XW'(1);
          end
        end
      end
      S_CPRD: begin
        st_nxt = S_CPWR;
      end
      S_CPWR: begin
        st_nxt = S_CPRD;
        if (last_col) pass_end = 1'b1;
        else i_nxt = i_r + XW'(1);
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
    if (pass_end) begin
      buf_nxt  = ~buf_r;
      left_nxt = left_r - PASS_W'(1);
      i_nxt    = '0;
      j_nxt    = '0;
      base_nxt = '0;
      k_nxt    = '0;
      if (left_r == PASS_W'(1)) begin
        st_nxt   = S_IDLE;
        done_nxt = 1'b1;
      end else begin
        st_nxt = S_CELL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      done_r <= 1'b0;
      buf_r  <= 1'b0;
      k_r    <= '0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
      buf_r  <= buf_nxt;
      k_r    <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r  <= mode_nxt;
    cols_r  <= cols_nxt;
    rows_r  <= rows_nxt;
    lastb_r <= lastb_nxt;
    left_r  <= left_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    base_r  <= base_nxt;
    acc_r   <= acc_nxt;
    zero_r  <= zero_nxt;
  end

  assign stat_o.busy    = (st_r != S_IDLE);
  assign stat_o.done    = done_r;
  assign stat_o.buf_sel = buf_r;

endmodule
`default_nettype wire

// ===== rtl/grid_laplacian_smoother.sv =====
`default_nettype none
// A load is written to frame memory at its accepting edge; a read goes to T_RD, where the
//   memory data is registered, and out_valid follows from T_RD and holds until taken.
// Loads one request per cycle while no result waits and no pass runs; a read is taken only
//   once the last result has left the output register (in_stall is high while it waits).
// The load that completes the frame starts pass_count passes (none if zero) on the shared
//   cell unit: one frame memory read each for center and four neighbors per cell, over
//   every cell in boundary modes 1 to 3, or all rows but the last plus a seam row copy in
//   mode 0. in_stall is high meanwhile.
// Reset (rst_n, synchronous): positions and buffer select clear, registers take their
//   defaults; frame memory is not cleared.
module grid_laplacian_smoother #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS = 256
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_action,
  input  wire logic [gls_pkg::SAMPLE_W-1:0]      in_sample_in,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [gls_pkg::SAMPLE_W-1:0]           out_sample_out,
  output logic                                   out_last_sample,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [gls_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [gls_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import gls_pkg::*;

  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int AW = $clog2(DEPTH);
  localparam int PW = $clog2(DEPTH + 1);
  localparam int CW = $clog2(((MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS) + 1);
  localparam int COLS_RST = (MAX_COLUMNS < 256) ? MAX_COLUMNS : 256;
  localparam int ROWS_RST = (MAX_ROWS < 256) ? MAX_ROWS : 256;

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_PASS = 2'd1;
  localparam logic [1:0] T_RD   = 2'd2;

  // clamp a written size to 3..limit
  function automatic logic [CW-1:0] size_clamp(input logic [CFG_DATA_W-1:0] v,
                                               input int lim);
    logic [CW-1:0] r;
    if (v < CFG_DATA_W'(3)) r = CW'(3);
    else if (32'(v) > lim) r = CW'(lim);
    else r = CW'(v);
    return r;
  endfunction

  logic [1:0]        st_r, st_nxt;
  logic [CW-1:0]     cols_r, rows_r;
  logic [PW-1:0]     total_r;
  logic [PASS_W-1:0] passes_r;
  logic [MODE_W-1:0] mode_r;
  logic [PW-1:0]     lp_r, lp_nxt, rp_r, rp_nxt;
  logic              cur_buf_r, cur_buf_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_last_r, out_last_nxt;
  logic [SAMPLE_W-1:0] out_sample_r;
  logic              pend_last_r, pend_last_nxt;

  logic              accept, is_load;
  logic [PW-1:0]     lp_eff, rp_eff, lp_inc;
  logic              frame_full;
  logic [CW-1:0]     cfg_size;

  job_t              job;
  stat_t             stat;
  logic              seq_rd_en, seq_wr_en;
  logic [AW:0]       seq_rd_addr, seq_wr_addr;
  logic [SAMPLE_W-1:0] seq_wr_data;

  logic              mem_wr_en, mem_rd_en;
  logic [AW:0]       mem_wr_addr, mem_rd_addr;
  logic [SAMPLE_W-1:0] mem_wr_data, mem_rd_data;

  // sequential: one request in flight, output must drain first
  assign in_stall  = (st_r != T_IDLE) | out_valid_r;
  assign accept    = in_valid & ~in_stall;
  assign is_load   = (in_action == ACT_LOAD);
  assign cfg_ready = 1'b1;

  // positions past a shrunken frame restart at zero
  assign lp_eff     = (lp_r >= total_r) ? '0 : lp_r;
  assign rp_eff     = (rp_r >= total_r) ? '0 : rp_r;
  assign lp_inc     = lp_eff + PW'(1);
  assign frame_full = (lp_inc == total_r);

  assign job.start  = (st_r == T_IDLE) & accept & is_load & frame_full & (passes_r != '0);
  assign job.mode   = mode_r;
  assign job.passes = passes_r;

  always_comb begin
    st_nxt        = st_r;
    lp_nxt        = lp_r;
    rp_nxt        = rp_r;
    cur_buf_nxt   = cur_buf_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_last_nxt  = out_last_r;
    pend_last_nxt = pend_last_r;
    case (st_r)
      T_IDLE: begin
        if (accept) begin
          if (is_load) begin
            lp_nxt = lp_inc;
            if (frame_full) begin
              lp_nxt = '0;
              rp_nxt = '0;
              if (passes_r != '0) st_nxt = T_PASS;
            end
          end else begin
            pend_last_nxt = (rp_eff == total_r - PW'(1));
            rp_nxt        = (rp_eff == total_r - PW'(1)) ? '0 : rp_eff + PW'(1);
            st_nxt        = T_RD;
          end
        end
      end
      T_PASS: begin
        if (stat.done) begin
          cur_buf_nxt = stat.buf_sel;
          st_nxt      = T_IDLE;
        end
      end
      T_RD: begin
        out_valid_nxt = 1'b1;
        out_last_nxt  = pend_last_r;
        st_nxt        = T_IDLE;
      end
      default: begin
        st_nxt = T_IDLE;
      end
    endcase
  end

  assign cfg_size = size_clamp(cfg_data, (cfg_index == REG_COLUMNS) ? MAX_COLUMNS : MAX_ROWS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= T_IDLE;
      lp_r        <= '0;
      rp_r        <= '0;
      cur_buf_r   <= 1'b0;
      out_valid_r <= 1'b0;
      cols_r      <= CW'(COLS_RST);
      rows_r      <= CW'(ROWS_RST);
      total_r     <= PW'(COLS_RST * ROWS_RST);
      passes_r    <= PASS_W'(1);
      mode_r      <= MODE_SEAM;
    end else begin
      st_r        <= st_nxt;
      lp_r        <= lp_nxt;
      rp_r        <= rp_nxt;
      cur_buf_r   <= cur_buf_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_COLUMNS: begin
            cols_r  <= cfg_size;
            total_r <= PW'(cfg_size * rows_r);
          end
          REG_ROWS: begin
            rows_r  <= cfg_size;
            total_r <= PW'(cols_r * cfg_size);
          end
          REG_PASSES: passes_r <= cfg_data[PASS_W-1:0];
          REG_MODE:   mode_r   <= cfg_data[MODE_W-1:0];
          default:    mode_r   <= mode_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_last_r  <= out_last_nxt;
    pend_last_r <= pend_last_nxt;
    if (st_r == T_RD) begin
      out_sample_r <= mem_rd_data;
    end
  end

  // frame memory port sharing: the pass unit owns both ports while it runs
  always_comb begin
    if (st_r == T_PASS) begin
      mem_wr_en   = seq_wr_en;
      mem_wr_addr = seq_wr_addr;
      mem_wr_data = seq_wr_data;
      mem_rd_en   = seq_rd_en;
      mem_rd_addr = seq_rd_addr;
    end else begin
      mem_wr_en   = accept & is_load;
      mem_wr_addr = {cur_buf_r, AW'(lp_eff)};
      mem_wr_data = in_sample_in;
      mem_rd_en   = accept & ~is_load;
      mem_rd_addr = {cur_buf_r, AW'(rp_eff)};
    end
  end

  gls_frame_mem #(
    .AW(AW + 1),
    .DW(SAMPLE_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  gls_pass_seq #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS(MAX_ROWS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_i     (job),
    .cols_i    (cols_r),
    .rows_i    (rows_r),
    .total_i   (total_r),
    .src_buf_i (cur_buf_r),
    .stat_o    (stat),
    .rd_en_o   (seq_rd_en),
    .rd_addr_o (seq_rd_addr),
    .rd_data_i (mem_rd_data),
    .wr_en_o   (seq_wr_en),
    .wr_addr_o (seq_wr_addr),
    .wr_data_o (seq_wr_data)
  );

  assign out_valid       = out_valid_r;
  assign out_sample_out  = out_sample_r;
  assign out_last_sample = out_last_r;

endmodule
`default_nettype wire

// ===== tb/sv/smoother_checker.sv =====
`timescale 1ns / 1ps
module smoother_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  input  wire logic                           in_stall,
  input  wire logic                           in_action,
  input  wire logic [gls_pkg::SAMPLE_W-1:0]   in_sample_in,
  input  wire logic                           out_valid,
  input  wire logic                           out_stall,
  input  wire logic [gls_pkg::SAMPLE_W-1:0]   out_sample_out,
  input  wire logic                           out_last_sample,
  input  wire logic                           cfg_valid,
  input  wire logic                           cfg_ready,
  input  wire logic [gls_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gls_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                  fail_count,
  output int                                  pending
);
  import gls_pkg::*;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } height_t;

  localparam int DEPTH = 256 * 256;

  logic [SAMPLE_W-1:0]   frame_mem [2][DEPTH];
  logic [CFG_DATA_W-1:0] col_reg, row_reg;
  logic [PASS_W-1:0]     pass_reg;
  logic [MODE_W-1:0]     mode_reg;
  int                    load_pos, read_pos;
  bit                    cur_buf;
  height_t               expected_heights[$];

  assign pending = expected_heights.size();

  function automatic int clamp_dim(int v);
    if (v < 3) return 3;
    if (v > 256) return 256;
    return v;
  endfunction

  function automatic int height_at(bit sel, int col, int row, int cols, int rows);
    if (col < 0 || row < 0 || col >= cols || row >= rows) return 0;
    return frame_mem[sel][row * cols + col];
  endfunction

  task automatic smooth_pass(int cols, int rows);
    int  i, j, ip, im, jp, jm, rlim, nsum, acc;
    bit  src;
    src = cur_buf;
    rlim = (mode_reg == MODE_SEAM) ? rows - 1 : rows;
    for (j = 0; j < rlim; j++) begin
      for (i = 0; i < cols; i++) begin
        if (mode_reg == MODE_SEAM) begin
          ip = (i + 1 > cols - 1) ? cols - 1 : i + 1;
          im = (i == 0) ? 0 : i - 1;
          jp = (j + 1 >= rows - 1) ? 0 : j + 1;
          jm = (j == 0) ? rows - 2 : j - 1;
        end else if (mode_reg == MODE_WRAP) begin
          ip = (i + 1 >= cols) ? 0 : i + 1;
          im = (i == 0) ? cols - 1 : i - 1;
          jp = (j + 1 > rows - 1) ? rows - 1 : j + 1;
          jm = (j == 0) ? 0 : j - 1;
        end else begin
          ip = i + 1; im = i - 1; jp = j + 1; jm = j - 1;
        end
        nsum = height_at(src, ip, j, cols, rows) + height_at(src, im, j, cols, rows)
             + height_at(src, i, jp, cols, rows) + height_at(src, i, jm, cols, rows);
        acc = 4 * height_at(src, i, j, cols, rows) + nsum + 4;
        frame_mem[!src][j * cols + i] = acc[SAMPLE_W+2:3];
      end
    end
    if (mode_reg == MODE_SEAM)
      for (i = 0; i < cols; i++) frame_mem[!src][(rows - 1) * cols + i] = frame_mem[!src][i];
    cur_buf = !cur_buf;
  endtask

  always @(posedge clk) begin
    int      cols, rows, total, p;
    height_t want;
    if (!rst_n) begin
      col_reg <= 9'd256; row_reg <= 9'd256; pass_reg <= 8'd1; mode_reg <= MODE_SEAM;
      load_pos = 0; read_pos = 0; cur_buf = 0;
      expected_heights.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_COLUMNS: col_reg <= cfg_data;
          REG_ROWS:    row_reg <= cfg_data;
          REG_PASSES:  pass_reg <= cfg_data[PASS_W-1:0];
          REG_MODE:    mode_reg <= cfg_data[MODE_W-1:0];
          default:     ;
        endcase
      end
      if (in_valid && !in_stall) begin
        cols = clamp_dim(col_reg);
        rows = clamp_dim(row_reg);
        total = cols * rows;
        if (in_action == ACT_LOAD) begin
          if (load_pos >= total) load_pos = 0;
          frame_mem[cur_buf][load_pos] = in_sample_in;
          load_pos++;
          if (load_pos >= total) begin
            for (p = 0; p < pass_reg; p++) smooth_pass(cols, rows);
            load_pos = 0;
            read_pos = 0;
          end
        end else begin
          if (read_pos >= total) read_pos = 0;
          want.sample = frame_mem[cur_buf][read_pos];
          want.last = (read_pos == total - 1);
          expected_heights.push_back(want);
          read_pos++;
          if (read_pos >= total) read_pos = 0;
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_heights.size() == 0) begin
          if (fail_count < 10) $display("unexpected height %h last %b", out_sample_out,
                                        out_last_sample);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_heights.pop_front();
          if (want.sample !== out_sample_out || want.last !== out_last_sample) begin
            if (fail_count < 10)
              $display("height mismatch: exp %h last %b, got %h last %b",
                       want.sample, want.last, out_sample_out, out_last_sample);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import gls_pkg::*;

  logic                  clk, rst_n;
  logic                  in_valid, in_stall, in_action;
  logic [SAMPLE_W-1:0]   in_sample_in;
  logic                  out_valid, out_stall, out_last_sample;
  logic [SAMPLE_W-1:0]   out_sample_out;
  logic                  cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count, pending;

  int cycle_count;
  int sent;        // accepted requests
  int burst_left;  // requests left in the current sender burst

  grid_laplacian_smoother u_dut (.*);

  smoother_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Watchdog: the worst phase here is 255 passes on up to 16 cells; the limit
  // leaves a wide margin over the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Receiver backpressure: the style changes with cycle_count, including
  // no-stall stretches and long stall runs.
  always @(posedge clk) begin
    case ((cycle_count / 400) % 4)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      2: out_stall <= ($urandom_range(0, 9) < 8);
      default: out_stall <= (cycle_count % 7) < 3;
    endcase
  end

  // One request; valid stays up across back-to-back requests in a burst.
  task automatic send_request(logic act, logic [SAMPLE_W-1:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_sample_in <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    sent++;
  endtask

  // Drain all reads, let any smoothing passes finish, then go idle.
  task automatic quiesce();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_height();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return SAMPLE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic int eff_dim(int v);
    return (v < 3) ? 3 : (v > 256) ? 256 : v;
  endfunction

  // One setting: full frame load, reads past the frame end (wraps), sparse
  // stray loads between reads, optionally a partial frame left behind so the
  // next size change exercises the position reset.
  task automatic run_phase(int cols, int rows, int passes, int mode, int extra,
                           bit leave_partial);
    int total, k;
    quiesce();
    write_reg(REG_COLUMNS, CFG_DATA_W'(cols));
    write_reg(REG_ROWS, CFG_DATA_W'(rows));
    write_reg(REG_PASSES, CFG_DATA_W'(passes));
    write_reg(REG_MODE, CFG_DATA_W'(mode));
    cfg_valid <= 1'b0;
    total = eff_dim(cols) * eff_dim(rows);
    for (k = 0; k < total; k++) send_request(ACT_LOAD, pick_height());
    for (k = 0; k < total + extra; k++) begin
      if ($urandom_range(0, 24) == 0) send_request(ACT_LOAD, pick_height());
      else send_request(!ACT_LOAD, pick_height());
    end
    if (leave_partial)
      for (k = $urandom_range(1, total - 1); k > 0; k--) send_request(ACT_LOAD, pick_height());
  endtask

  initial begin
    int cols, rows, passes;
    rst_n = 0;
    in_valid = 0; in_action = 0; in_sample_in = 0;
    out_stall = 0;
    cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    cycle_count = 0; sent = 0; burst_left = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: each boundary mode, mode three, zero and max passes,
    // clamped sizes at both ends
    run_phase(3, 3, 1, MODE_SEAM, 2, 0);
    run_phase(4, 3, 2, MODE_WRAP, 1, 0);
    run_phase(3, 4, 3, MODE_ZERO, 1, 1);
    run_phase(3, 3, 1, 3, 0, 0);
    run_phase(3, 3, 0, MODE_SEAM, 3, 0);
    run_phase(3, 3, 255, MODE_SEAM, 0, 0);
    run_phase(0, 5, 1, MODE_WRAP, 0, 1);
    run_phase(511, 2, 2, MODE_SEAM, 0, 0);
    run_phase(1, 3, 1, MODE_ZERO, 0, 1);

    // random settings, small grids only
    while (sent < 1500) begin
      cols = $urandom_range(0, 9);
      rows = $urandom_range(0, 9);
      passes = (eff_dim(cols) * eff_dim(rows) <= 16 && $urandom_range(0, 5) == 0) ?
               $urandom_range(0, 255) : $urandom_range(0, 4);
      run_phase(cols, rows, passes, $urandom_range(0, 3), $urandom_range(0, 20),
                $urandom_range(0, 3) == 0);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
